>>> src/rl_pkg.sv
`timescale 1ns / 1ps

package rl_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int WORD_W        = 32;
	localparam int CNT_W         = 16;
	localparam int QLEV_W        = 16;
	localparam int IN_W          = 80;
	localparam int OUT_W         = 40;
	localparam int PADDR_W       = 4;
	localparam int PDATA_W       = 32;

	localparam logic [1:0] REG_MIN_INTERVAL = 2'd0;
	localparam logic [1:0] REG_MAX_PER_SRC  = 2'd1;
	localparam logic [1:0] REG_WINDOW       = 2'd2;
	localparam logic [1:0] REG_MAX_QUEUE    = 2'd3;

	typedef enum logic [1:0] {
		OP_ADMIT = 2'd0,
		OP_SWEEP = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		V_ADMIT = 3'd0,
		V_SOON  = 3'd1,
		V_LIMIT = 3'd2,
		V_QUEUE = 3'd3,
		V_MAINT = 3'd4
	} verdict_t;

	typedef struct packed {
		logic [16:0]       min_interval;
		logic [CNT_W-1:0]  max_per_source;
		logic [19:0]       window;
		logic [QLEV_W-1:0] max_queue;
	} cfg_t;

	typedef struct packed {
		logic [WORD_W-1:0] addr;
		logic [WORD_W-1:0] last_time;
		logic [CNT_W-1:0]  count;
	} entry_t;

	typedef struct packed {
		logic load;
		logic scan_rd;
		logic commit;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		op_t  op;
		logic scan_last;
	} dp_stat_t;

endpackage

>>> src/rl_cfg.sv
`timescale 1ns / 1ps

module rl_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rl_pkg::PADDR_W-1:0]  paddr,
	input  logic [rl_pkg::PDATA_W-1:0]  pwdata,
	output logic [rl_pkg::PDATA_W-1:0]  prdata,
	output logic                        pready,
	output rl_pkg::cfg_t                cfg
);
	import rl_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_interval   <= 17'd60;
			cfg_q.max_per_source <= 16'd5;
			cfg_q.window         <= 20'd3600;
			cfg_q.max_queue      <= 16'd100;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_MIN_INTERVAL: cfg_q.min_interval   <= pwdata[16:0];
				REG_MAX_PER_SRC:  cfg_q.max_per_source <= pwdata[15:0];
				REG_WINDOW:       cfg_q.window         <= pwdata[19:0];
				REG_MAX_QUEUE:    cfg_q.max_queue      <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_MIN_INTERVAL: prdata = PDATA_W'(cfg_q.min_interval);
			REG_MAX_PER_SRC:  prdata = PDATA_W'(cfg_q.max_per_source);
			REG_WINDOW:       prdata = PDATA_W'(cfg_q.window);
			REG_MAX_QUEUE:    prdata = PDATA_W'(cfg_q.max_queue);
			default:          prdata = '0;
		endcase
	end

endmodule

>>> src/rl_dp.sv
`timescale 1ns / 1ps

module rl_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rl_pkg::cfg_t              cfg,
	input  rl_pkg::dp_cmd_t           cmd,
	output rl_pkg::dp_stat_t          stat,
	input  logic [rl_pkg::IN_W-1:0]   s_tdata,
	input  logic [1:0]                s_tuser,
	output logic [rl_pkg::OUT_W-1:0]  m_tdata
);
	import rl_pkg::*;

	entry_t mem_q [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;

	op_t               op_q;
	logic [WORD_W-1:0] addr_q;
	logic [WORD_W-1:0] now_q;
	logic [QLEV_W-1:0] qlev_q;

	logic [IDX_W-1:0]  rd_idx_q;
	logic              scan_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              vld_s1;
	entry_t            rd_s1;

	logic              hit_q;
	logic [IDX_W-1:0]  hit_idx_q;
	logic [WORD_W-1:0] hit_el_q;
	logic [CNT_W-1:0]  hit_cnt_q;
	logic              free_q;
	logic [IDX_W-1:0]  free_idx_q;
	logic [IDX_W-1:0]  old_idx_q;
	logic [WORD_W-1:0] old_age_q;

	logic [WORD_W-1:0] rej_q;
	verdict_t          verdict_q;
	logic [OUT_W-1:0]  out_data_q;

	logic [WORD_W-1:0] el_s1;
	logic [WORD_W-1:0] sweep_lim;
	logic              soon;
	logic              over;
	logic              qfull;
	logic              reject;
	verdict_t          verdict_d;
	logic [IDX_W-1:0]  wr_idx;
	entry_t            wr_data;
	logic              admit_wr;

	assign stat.op        = op_q;
	assign stat.scan_last = (rd_idx_q == IDX_W'(TABLE_ENTRIES - 1));
	assign m_tdata        = out_data_q;

	assign el_s1     = now_q - rd_s1.last_time;
	assign sweep_lim = WORD_W'({cfg.window, 1'b0});

	// decision on the gathered scan results
	always_comb begin
		soon   = hit_q && (hit_el_q < WORD_W'(cfg.min_interval));
		over   = hit_q && !soon && (hit_cnt_q >= cfg.max_per_source)
		         && (hit_el_q < WORD_W'(cfg.window));
		qfull  = !soon && !over && (qlev_q >= cfg.max_queue);
		reject = soon || over || qfull;
		if (soon) begin
			verdict_d = V_SOON;
		end else if (over) begin
			verdict_d = V_LIMIT;
		end else if (qfull) begin
			verdict_d = V_QUEUE;
		end else begin
			verdict_d = V_ADMIT;
		end

		wr_data.addr      = addr_q;
		wr_data.last_time = now_q;
		if (hit_q) begin
			wr_idx = hit_idx_q;
			if (hit_el_q >= WORD_W'(cfg.window)) begin
				wr_data.count = CNT_W'(1);
			end else if (hit_cnt_q == '1) begin
				wr_data.count = hit_cnt_q;
			end else begin
				wr_data.count = hit_cnt_q + CNT_W'(1);
			end
		end else begin
			wr_idx        = free_q ? free_idx_q : old_idx_q;
			wr_data.count = CNT_W'(1);
		end
		admit_wr = cmd.commit && (op_q == OP_ADMIT) && !reject;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op_t'(s_tuser);
			addr_q <= s_tdata[31:0];
			now_q  <= s_tdata[63:32];
			qlev_q <= s_tdata[79:64];
		end
	end

	// table memory: one read port for the scan, one write port for the update
	always_ff @(posedge clk) begin
		if (admit_wr) begin
			mem_q[wr_idx] <= wr_data;
		end
		rd_s1  <= mem_q[rd_idx_q];
		idx_s1 <= rd_idx_q;
		vld_s1 <= valid_q[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
			scan_s1  <= 1'b0;
		end else begin
			scan_s1 <= cmd.scan_rd;
			if (cmd.load) begin
				rd_idx_q <= '0;
			end else if (cmd.scan_rd && !stat.scan_last) begin
				rd_idx_q <= rd_idx_q + IDX_W'(1);
			end
		end
	end

	// accumulate first match, first free slot and the oldest entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (cmd.load) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (scan_s1 && (op_q == OP_ADMIT)) begin
			if (vld_s1 && (rd_s1.addr == addr_q) && !hit_q) begin
				hit_q <= 1'b1;
			end
			if (!vld_s1 && !free_q) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_s1 && (op_q == OP_ADMIT)) begin
			if (vld_s1 && (rd_s1.addr == addr_q) && !hit_q) begin
				hit_idx_q <= idx_s1;
				hit_el_q  <= el_s1;
				hit_cnt_q <= rd_s1.count;
			end
			if (!vld_s1 && !free_q) begin
				free_idx_q <= idx_s1;
			end
			if ((idx_s1 == '0) || (el_s1 > old_age_q)) begin
				old_idx_q <= idx_s1;
				old_age_q <= el_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.commit && (op_q == OP_CLEAR)) begin
			valid_q <= '0;
		end else if (admit_wr) begin
			valid_q[wr_idx] <= 1'b1;
		end else if (scan_s1 && (op_q == OP_SWEEP) && vld_s1 && (el_s1 > sweep_lim)) begin
			valid_q[idx_s1] <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rej_q <= '0;
		end else if (cmd.commit && (op_q == OP_ADMIT) && reject) begin
			rej_q <= rej_q + WORD_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			verdict_q <= (op_q == OP_ADMIT) ? verdict_d : V_MAINT;
		end
		if (cmd.out_load) begin
			out_data_q <= {4'b0000, rej_q, verdict_q, (verdict_q == V_ADMIT)};
		end
	end

endmodule

>>> src/rl_ctrl.sv
`timescale 1ns / 1ps

module rl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  rl_pkg::dp_stat_t  stat,
	output rl_pkg::dp_cmd_t   cmd
);
	import rl_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_DRAIN  = 5'b00100,
		ST_DECIDE = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.load     = s_tvalid && (state_q == ST_IDLE);
		cmd.scan_rd  = (state_q == ST_SCAN);
		cmd.commit   = (state_q == ST_DECIDE);
		cmd.out_load = (state_q == ST_FINISH) && (!out_valid_q || m_tready);
		state_d      = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// clear and unused commands skip the walk
				if ((stat.op == OP_CLEAR) || (stat.op == OP_NONE)) begin
					cmd.scan_rd = 1'b0;
					state_d     = ST_DECIDE;
				end else if (stat.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN:  state_d = ST_DECIDE;
			ST_DECIDE: state_d = ST_FINISH;
			ST_FINISH: begin
				if (cmd.out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> src/per_source_rate_limiter.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                      Payload
// s_*       in         s_tvalid / s_tready            request: tuser cmd, tdata fields
// m_*       out        m_tvalid / m_tready            result: admitted, verdict, total
// APB       in         psel, penable, pwrite, pready  four configuration registers
//
// Admission and sweep walk the source table through its single read port, one entry
// per cycle. Clear and the unused command skip the walk.
// arst_n empties the table, zeroes the reject count and loads register defaults.
// A result held by m_tready = 0 stays in the output register; the next request is
// still taken and waits in its last step until the output register frees up.

module per_source_rate_limiter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [rl_pkg::IN_W-1:0]     s_tdata,  // source_address, now_seconds, queue_level
	input  logic [1:0]                  s_tuser,  // cmd
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [rl_pkg::OUT_W-1:0]    m_tdata,  // admitted, verdict, rejected_total, pad
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rl_pkg::PADDR_W-1:0]  paddr,
	input  logic [rl_pkg::PDATA_W-1:0]  pwdata,
	output logic [rl_pkg::PDATA_W-1:0]  prdata,
	output logic                        pready
);
	import rl_pkg::*;

	cfg_t     cfg;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	rl_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rl_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cmd     (cmd),
		.stat    (stat),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tdata (m_tdata)
	);

endmodule

>>> bench/per_source_rate_limiter_tb.sv
`timescale 1ns / 1ps

module per_source_rate_limiter_tb;

	import rl_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;

	typedef struct packed {
		logic        admitted;
		verdict_t    verdict;
		logic [31:0] total;
	} decision_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata;  // source_address, now_seconds, queue_level
	logic [1:0]           s_tuser;  // cmd
	logic                 m_tvalid;
	logic                 m_tready;
	logic [OUT_W-1:0]     m_tdata;  // admitted, verdict, rejected_total, pad
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [PDATA_W-1:0]   pwdata;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;

	// shadow of the source table and the limits
	bit          src_valid [TABLE_ENTRIES];
	logic [31:0] src_addr  [TABLE_ENTRIES];
	logic [31:0] src_last  [TABLE_ENTRIES];
	logic [15:0] src_count [TABLE_ENTRIES];
	logic [31:0] reject_total;
	logic [16:0] lim_min_gap;
	logic [15:0] lim_per_src;
	logic [19:0] lim_window;
	logic [15:0] lim_queue;

	decision_t   pending_decisions[$];
	logic [31:0] addr_pool[$];
	logic [31:0] cur_now;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          err_count;
	int          quiet_cycles;

	per_source_rate_limiter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic void decide_request(input op_t op, input logic [31:0] addr,
			input logic [31:0] now, input logic [15:0] qlev, output decision_t d);
		int          hit;
		int          slot;
		logic [31:0] el;
		logic [31:0] age;
		logic [31:0] best_age;
		logic [32:0] stale_lim;
		verdict_t    v;
		hit = -1;
		el = '0;
		v = V_MAINT;
		case (op)
		OP_ADMIT: begin
			for (int i = 0; i < TABLE_ENTRIES && hit < 0; i++)
				if (src_valid[i] && src_addr[i] == addr)
					hit = i;
			v = V_ADMIT;
			if (hit >= 0) begin
				el = now - src_last[hit];
				if (el < lim_min_gap)
					v = V_SOON;
				else if (src_count[hit] >= lim_per_src && el < lim_window)
					v = V_LIMIT;
			end
			if (v == V_ADMIT && qlev >= lim_queue)
				v = V_QUEUE;
			if (v != V_ADMIT) begin
				reject_total = reject_total + 32'd1;
			end else if (hit >= 0) begin
				if (el >= lim_window)
					src_count[hit] = 16'd1;
				else if (src_count[hit] != 16'hFFFF)
					src_count[hit] = src_count[hit] + 16'd1;
				src_last[hit] = now;
			end else begin
				slot = -1;
				for (int i = 0; i < TABLE_ENTRIES && slot < 0; i++)
					if (!src_valid[i])
						slot = i;
				// table full: evict the entry idle the longest, lowest index on a tie
				if (slot < 0) begin
					slot = 0;
					best_age = now - src_last[0];
					for (int i = 1; i < TABLE_ENTRIES; i++) begin
						age = now - src_last[i];
						if (age > best_age) begin
							slot = i;
							best_age = age;
						end
					end
				end
				src_valid[slot] = 1'b1;
				src_addr[slot] = addr;
				src_last[slot] = now;
				src_count[slot] = 16'd1;
			end
		end
		OP_SWEEP: begin
			stale_lim = {12'd0, lim_window, 1'b0};
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				age = now - src_last[i];
				if (src_valid[i] && {1'b0, age} > stale_lim)
					src_valid[i] = 1'b0;
			end
		end
		OP_CLEAR: begin
			for (int i = 0; i < TABLE_ENTRIES; i++)
				src_valid[i] = 1'b0;
		end
		default: begin
		end
		endcase
		d.admitted = (v == V_ADMIT);
		d.verdict = v;
		d.total = reject_total;
	endfunction

	task automatic send_request(input op_t op, input logic [31:0] addr,
			input logic [31:0] now, input logic [15:0] qlev);
		decision_t d;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {qlev, now, addr};
		do @(posedge clk); while (!s_tready);
		decide_request(op, addr, now, qlev, d);
		pending_decisions.push_back(d);
	endtask

	// hold until every result is back and the block has settled
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_decisions.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
		REG_MIN_INTERVAL: lim_min_gap = val[16:0];
		REG_MAX_PER_SRC:  lim_per_src = val[15:0];
		REG_WINDOW:       lim_window = val[19:0];
		REG_MAX_QUEUE:    lim_queue = val[15:0];
		default: begin
		end
		endcase
		@(posedge clk);
	endtask

	task automatic apply_limits(input int min_gap, input int per_src, input int window,
			input int max_queue);
		drain_results();
		write_reg(REG_MIN_INTERVAL, min_gap);
		write_reg(REG_MAX_PER_SRC, per_src);
		write_reg(REG_WINDOW, window);
		write_reg(REG_MAX_QUEUE, max_queue);
	endtask

	// advance the clock mostly around the configured interval and window
	function automatic logic [31:0] next_now(input logic [31:0] t);
		int r;
		r = $urandom_range(99);
		if (r < 30)
			return t + $urandom_range(0, lim_min_gap);
		else if (r < 60)
			return t + lim_min_gap + $urandom_range(0, 3);
		else if (r < 80)
			return t + $urandom_range(0, lim_window + 2);
		else if (r < 92)
			return t + 2 * lim_window + $urandom_range(0, 2);
		else if (r < 97)
			return t + $urandom;
		return t - $urandom_range(1, 100);
	endfunction

	task automatic random_traffic(input int n, input int pool_n, input int maint_pct,
			input int idle_pct, input int stall_pct);
		int          r;
		op_t         op;
		logic [31:0] addr;
		logic [15:0] qlev;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		addr_pool.delete();
		for (int i = 0; i < pool_n; i++)
			addr_pool.push_back($urandom);
		for (int k = 0; k < n; k++) begin
			op = OP_ADMIT;
			if ($urandom_range(99) < maint_pct) begin
				r = $urandom_range(2);
				op = (r == 0) ? OP_SWEEP : (r == 1) ? OP_CLEAR : OP_NONE;
			end
			if ($urandom_range(9) == 0)
				addr = $urandom;
			else
				addr = addr_pool[$urandom_range(0, pool_n - 1)];
			r = $urandom_range(99);
			if (r < 70)
				qlev = 16'($urandom_range(0, lim_queue));
			else if (r < 85)
				qlev = 16'(lim_queue - $urandom_range(0, 1));
			else
				qlev = 16'($urandom);
			cur_now = next_now(cur_now);
			send_request(op, addr, cur_now, qlev);
		end
	endtask

	task automatic test_directed_defaults();
		logic [31:0] t0;
		logic [31:0] a0;
		logic [31:0] a1;
		t0 = 32'h7000_0000;
		a0 = 32'h0000_0000;
		a1 = 32'hFFFF_FFFF;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_request(OP_ADMIT, a0, t0, 16'd0);
		send_request(OP_ADMIT, a0, t0 + 59, 16'd0);
		send_request(OP_ADMIT, a0, t0 + 60, 16'd99);
		send_request(OP_ADMIT, a0, t0 + 120, 16'd100);
		for (int k = 3; k <= 5; k++)
			send_request(OP_ADMIT, a0, t0 + 60 * k, 16'd0);
		send_request(OP_ADMIT, a0, t0 + 360, 16'd0);
		send_request(OP_ADMIT, a0, t0 + 3900, 16'hFFFF);
		send_request(OP_ADMIT, a0, t0 + 3900, 16'd0);
		send_request(OP_ADMIT, a1, 32'hFFFF_FFFF, 16'd0);
		// wrapped and backwards times
		send_request(OP_ADMIT, a1, 32'h0000_0010, 16'd0);
		send_request(OP_ADMIT, a1, 32'hFFFF_FF00, 16'd0);
		send_request(OP_NONE, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 16'hFFFF);
		send_request(OP_SWEEP, a0, t0 + 11100, 16'd0);
		send_request(OP_ADMIT, a1, 32'hFFFF_FF0A, 16'd0);
		send_request(OP_ADMIT, a0, t0 + 11100, 16'd0);
		send_request(OP_ADMIT, a0, t0 + 11101, 16'd0);
		send_request(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		send_request(OP_ADMIT, a0, t0 + 11102, 16'd0);
	endtask

	task automatic test_nominal_traffic();
		apply_limits(60, 5, 3600, 100);
		random_traffic(140, 12, 10, 0, 0);
	endtask

	task automatic test_upper_limits();
		apply_limits(86400, 65535, 604800, 65535);
		random_traffic(120, 10, 10, 66, 0);
	endtask

	task automatic test_lower_limits();
		apply_limits(0, 0, 0, 0);
		random_traffic(40, 8, 10, 0, 66);
	endtask

	task automatic test_no_allowance();
		apply_limits(0, 0, 604800, 65535);
		random_traffic(120, 10, 10, 0, 66);
	endtask

	task automatic test_zero_window();
		apply_limits(86400, 1, 0, 50);
		random_traffic(120, 8, 15, 37, 37);
	endtask

	task automatic test_short_window();
		apply_limits(30, 3, 12, 1000);
		random_traffic(150, 6, 12, 37, 37);
	endtask

	task automatic test_table_full();
		apply_limits(5, 4, 400, 65535);
		random_traffic(150, 100, 1, 0, 0);
	endtask

	always @(posedge clk) begin : result_check
		decision_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_decisions.size() == 0) begin
				$display("%0t: unexpected result admitted %0b verdict %0d total %0d",
					$time, m_tdata[0], m_tdata[3:1], m_tdata[35:4]);
				err_count++;
			end else begin
				want = pending_decisions.pop_front();
				if (m_tdata[0] !== want.admitted) begin
					$display("%0t: admitted expected %0b actual %0b",
						$time, want.admitted, m_tdata[0]);
					err_count++;
				end
				if (m_tdata[3:1] !== want.verdict) begin
					$display("%0t: verdict expected %0d actual %0d",
						$time, want.verdict, m_tdata[3:1]);
					err_count++;
				end
				if (m_tdata[35:4] !== want.total) begin
					$display("%0t: rejected_total expected %0d actual %0d",
						$time, want.total, m_tdata[35:4]);
					err_count++;
				end
			end
		end
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("per_source_rate_limiter_tb NOT OK");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= OP_ADMIT;
		m_tready <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		err_count = 0;
		quiet_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < TABLE_ENTRIES; i++)
			src_valid[i] = 1'b0;
		reject_total = '0;
		lim_min_gap = 17'd60;
		lim_per_src = 16'd5;
		lim_window = 20'd3600;
		lim_queue = 16'd100;
		cur_now = $urandom;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_defaults();
		test_nominal_traffic();
		test_upper_limits();
		test_lower_limits();
		test_no_allowance();
		test_zero_window();
		test_short_window();
		test_table_full();

		drain_results();
		repeat (TABLE_ENTRIES + 8) @(posedge clk);
		if (err_count == 0 && pending_decisions.size() == 0)
			$display("per_source_rate_limiter_tb OK");
		else
			$display("per_source_rate_limiter_tb NOT OK");
		$finish;
	end

endmodule
